// ----- sv/lphm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_pkg
// shared types and constants of the linear probing hash map
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int KEY_W      = 64;  // key field
  localparam int VAL_W      = 32;  // value field
  localparam int SIZE_W     = 7;   // table size register and free count
  localparam int LIMIT_W    = 4;   // key length register and byte counts
  localparam int SUM_W      = 11;  // byte sum, at most 8 * 255
  localparam int CFG_W      = 7;   // widest config register
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_SLOT_W = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KEY_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MOD,
    S_PROBE_RD,
    S_PROBE_CHK
  } state_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage
`default_nettype wire

// ----- sv/lphm_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module lphm_mod (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire  [lphm_pkg::SUM_W-1:0]      dividend,
  input  wire  [lphm_pkg::SIZE_W-1:0]     divisor,
  output logic                            done,
  output logic [lphm_pkg::SIZE_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(lphm_pkg::SUM_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lphm_pkg::SUM_W - 1);

  logic                        active;
  logic [CNT_W-1:0]            cnt;
  logic [lphm_pkg::SUM_W-1:0]  dvd;
  logic [lphm_pkg::SIZE_W:0]   trial;
  logic [lphm_pkg::SIZE_W:0]   diff;
  logic                        ge;

  // shift in the next dividend bit, subtract when it fits
  assign trial = {remainder, dvd[lphm_pkg::SUM_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active    <= 1'b1;
        cnt       <= '0;
        dvd       <= dividend;
        remainder <= '0;
      end else if (active) begin
        dvd       <= {dvd[lphm_pkg::SUM_W-2:0], 1'b0};
        remainder <= ge ? diff[lphm_pkg::SIZE_W-1:0] : trial[lphm_pkg::SIZE_W-1:0];
        cnt       <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/linear_probe_hash_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// open addressing map from short byte string keys to 32-bit values
// ----------------------------------------------------------------------------
// A request (insert or find) is taken when start is high and busy is low; the
// block then stays busy until its single result is shown on status,
// found_value and slot for exactly one cycle with done high. The receiver
// cannot stall, so results must be taken as they come. A request passes
// through the byte summing sequencer, one key byte per scan cycle, then
// the eleven steps of the shared remainder unit that reduces the sum modulo
// the table size, then a read state and a check state per probed slot for
// the registered read of the slot memory. A request stopped by the full
// table check or the key length check skips the remainder unit and the
// probe. After reset, and after every write of table_size, a clearing pass
// walks every slot of the slot memory with busy high; configuration writes
// are still taken during the pass.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BYTES   = 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // request side
  input  wire                                   start,
  output logic                                  busy,
  input  wire                                   command,
  input  wire  [lphm_pkg::KEY_W-1:0]            key,
  input  wire  signed [lphm_pkg::VAL_W-1:0]     value,
  // result side
  output logic                                  done,
  output logic [1:0]                            status,
  output logic signed [lphm_pkg::VAL_W-1:0]     found_value,
  output logic [lphm_pkg::OUT_SLOT_W-1:0]       slot,
  // configuration
  input  wire                                   cfg_write,
  input  wire  [lphm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [lphm_pkg::CFG_W-1:0]            cfg_data
);

  localparam int SLOT_W   = $clog2(TABLE_DEPTH);
  localparam int SIZE_W   = lphm_pkg::SIZE_W;
  localparam int LIMIT_W  = lphm_pkg::LIMIT_W;
  localparam int SUM_W    = lphm_pkg::SUM_W;
  localparam int KEY_W    = lphm_pkg::KEY_W;
  localparam int CMP_W    = (SLOT_W + 1 > SIZE_W) ? SLOT_W + 1 : SIZE_W;
  localparam int SIZE_CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
  localparam int SIZE_RST = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;

  localparam logic [SIZE_W-1:0]  SIZE_CAP_V  = SIZE_W'(SIZE_CAP);
  localparam logic [SIZE_W-1:0]  SIZE_RST_V  = SIZE_W'(SIZE_RST);
  localparam logic [LIMIT_W-1:0] KEY_BYTES_V = LIMIT_W'(KEY_BYTES);
  localparam logic [LIMIT_W-1:0] SCAN_LAST   = LIMIT_W'(KEY_BYTES - 1);
  localparam logic [SLOT_W-1:0]  CLEAR_LAST  = SLOT_W'(TABLE_DEPTH - 1);

  // --------------------------------------------------------------------------
  // control and working registers
  // --------------------------------------------------------------------------
  lphm_pkg::state_t state, state_next;

  logic [SLOT_W-1:0]             clr_addr, clr_addr_next;
  logic [SIZE_W-1:0]             size_eff, size_eff_next;     // effective table size
  logic [LIMIT_W-1:0]            key_limit, key_limit_next;   // effective max key length
  logic [SIZE_W-1:0]             free_count, free_count_next;

  logic                          cmd, cmd_next;
  logic [lphm_pkg::VAL_W-1:0]    val_q, val_q_next;
  logic [KEY_W-1:0]              key_q, key_q_next;           // raw, then normalized key
  logic [KEY_W-1:0]              raw_shift, raw_shift_next;   // key bytes, low byte next
  logic [SUM_W-1:0]              sum, sum_next;
  logic [LIMIT_W-1:0]            len, len_next;
  logic                          ended, ended_next;           // zero byte seen
  logic [LIMIT_W-1:0]            scan_cnt, scan_cnt_next;
  logic [SLOT_W-1:0]             pos, pos_next;
  logic [SIZE_W-1:0]             probe_cnt, probe_cnt_next;

  logic                          done_next;
  logic [1:0]                    status_next;
  logic [lphm_pkg::VAL_W-1:0]    found_value_next;
  logic [lphm_pkg::OUT_SLOT_W-1:0] slot_next;

  // slot memory, one write and one registered read port
  lphm_pkg::entry_t              mem [TABLE_DEPTH];
  lphm_pkg::entry_t              rd_q;
  logic                          mem_we;
  logic [SLOT_W-1:0]             mem_addr;
  lphm_pkg::entry_t              mem_wdata;

  // shared remainder unit
  logic                          mod_start;
  logic                          mod_done;
  logic [SIZE_W-1:0]             mod_rem;

  // scan step helpers
  logic [7:0]                    cur_byte;
  logic                          take_byte;
  logic [SUM_W-1:0]              sum_upd;
  logic [LIMIT_W-1:0]            len_upd;
  logic [KEY_W-1:0]              key_norm;

  // probe helpers
  logic                          hit;
  logic                          wrap;
  logic [SLOT_W:0]               pos_inc;

  // config decode
  logic [SIZE_W-1:0]             cfg_size;
  logic [LIMIT_W-1:0]            cfg_limit;

  assign busy = (state != lphm_pkg::S_IDLE);

  lphm_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (sum_upd),
    .divisor   (size_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // one key byte per scan cycle
  assign cur_byte  = raw_shift[7:0];
  assign take_byte = !ended && (cur_byte != 8'd0);
  assign sum_upd   = take_byte ? (sum + SUM_W'(cur_byte)) : sum;
  assign len_upd   = take_byte ? (len + 1'b1) : len;

  // keep only the bytes before the terminator
  always_comb begin
    key_norm = '0;
    for (int j = 0; j < 8; j++) begin
      if (LIMIT_W'(j) < len_upd) begin
        key_norm[8*j +: 8] = key_q[8*j +: 8];
      end
    end
  end

  // a probe stops on a free slot or a matching key
  assign hit     = !rd_q.used || (rd_q.key == key_q);
  assign pos_inc = {1'b0, pos} + 1'b1;
  assign wrap    = (CMP_W'(pos_inc) >= CMP_W'(size_eff));

  // table size 0 acts as 1, anything above the depth as the depth
  assign cfg_size  = (cfg_data[SIZE_W-1:0] == '0)       ? SIZE_W'(1) :
                     (cfg_data[SIZE_W-1:0] > SIZE_CAP_V) ? SIZE_CAP_V :
                     cfg_data[SIZE_W-1:0];
  assign cfg_limit = (cfg_data[LIMIT_W-1:0] > KEY_BYTES_V) ? KEY_BYTES_V :
                     cfg_data[LIMIT_W-1:0];

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    size_eff_next    = size_eff;
    key_limit_next   = key_limit;
    free_count_next  = free_count;
    cmd_next         = cmd;
    val_q_next       = val_q;
    key_q_next       = key_q;
    raw_shift_next   = raw_shift;
    sum_next         = sum;
    len_next         = len;
    ended_next       = ended;
    scan_cnt_next    = scan_cnt;
    pos_next         = pos;
    probe_cnt_next   = probe_cnt;
    done_next        = 1'b0;
    status_next      = status;
    found_value_next = found_value;
    slot_next        = slot;
    mod_start        = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = pos;
    mem_wdata        = '{used: 1'b1, key: key_q, value: val_q};

    case (state)
      lphm_pkg::S_CLEAR: begin
        // mark every slot free, one per cycle
        mem_we        = 1'b1;
        mem_addr      = clr_addr;
        mem_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == CLEAR_LAST) begin
          state_next = lphm_pkg::S_IDLE;
        end
      end

      lphm_pkg::S_IDLE: begin
        if (start) begin
          cmd_next       = command;
          val_q_next     = value;
          key_q_next     = key;
          raw_shift_next = key;
          sum_next       = '0;
          len_next       = '0;
          ended_next     = 1'b0;
          scan_cnt_next  = '0;
          state_next     = lphm_pkg::S_SCAN;
        end
      end

      lphm_pkg::S_SCAN: begin
        sum_next       = sum_upd;
        len_next       = len_upd;
        ended_next     = !take_byte;
        raw_shift_next = {8'd0, raw_shift[KEY_W-1:8]};
        scan_cnt_next  = scan_cnt + 1'b1;
        if (scan_cnt == SCAN_LAST) begin
          key_q_next       = key_norm;
          found_value_next = '0;
          slot_next        = '0;
          if (cmd == lphm_pkg::CMD_INSERT && free_count == '0) begin
            // full check comes before the length check
            status_next = lphm_pkg::ST_FULL;
            done_next   = 1'b1;
            state_next  = lphm_pkg::S_IDLE;
          end else if (len_upd > key_limit) begin
            status_next = (cmd == lphm_pkg::CMD_INSERT) ? lphm_pkg::ST_TOO_LONG
                                                        : lphm_pkg::ST_NOT_FOUND;
            done_next   = 1'b1;
            state_next  = lphm_pkg::S_IDLE;
          end else begin
            mod_start  = 1'b1;
            state_next = lphm_pkg::S_MOD;
          end
        end
      end

      lphm_pkg::S_MOD: begin
        if (mod_done) begin
          pos_next       = SLOT_W'(mod_rem);
          probe_cnt_next = '0;
          state_next     = lphm_pkg::S_PROBE_RD;
        end
      end

      lphm_pkg::S_PROBE_RD: begin
        // slot read lands in rd_q at the end of this cycle
        state_next = lphm_pkg::S_PROBE_CHK;
      end

      lphm_pkg::S_PROBE_CHK: begin
        if (hit || probe_cnt == size_eff - 1'b1) begin
          done_next        = 1'b1;
          state_next       = lphm_pkg::S_IDLE;
          found_value_next = '0;
          slot_next        = '0;
          if (cmd == lphm_pkg::CMD_INSERT) begin
            if (hit) begin
              mem_we      = 1'b1;
              status_next = lphm_pkg::ST_OK;
              slot_next   = lphm_pkg::OUT_SLOT_W'(pos);
              if (!rd_q.used) begin
                free_count_next = free_count - 1'b1;
              end
            end else begin
              status_next = lphm_pkg::ST_FULL;
            end
          end else if (hit && rd_q.used) begin
            status_next      = lphm_pkg::ST_OK;
            found_value_next = rd_q.value;
            slot_next        = lphm_pkg::OUT_SLOT_W'(pos);
          end else begin
            status_next = lphm_pkg::ST_NOT_FOUND;
          end
        end else begin
          pos_next       = wrap ? '0 : pos_inc[SLOT_W-1:0];
          probe_cnt_next = probe_cnt + 1'b1;
          state_next     = lphm_pkg::S_PROBE_RD;
        end
      end

      default: begin
        state_next = lphm_pkg::S_IDLE;
      end
    endcase

    // register writes; a new table size empties the table
    if (cfg_write) begin
      case (cfg_index)
        lphm_pkg::REG_TABLE_SIZE: begin
          size_eff_next   = cfg_size;
          free_count_next = cfg_size;
          clr_addr_next   = '0;
          state_next      = lphm_pkg::S_CLEAR;
        end
        lphm_pkg::REG_MAX_KEY_LENGTH: begin
          key_limit_next = cfg_limit;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lphm_pkg::S_CLEAR;
      clr_addr   <= '0;
      size_eff   <= SIZE_RST_V;
      key_limit  <= KEY_BYTES_V;
      free_count <= SIZE_RST_V;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      size_eff   <= size_eff_next;
      key_limit  <= key_limit_next;
      free_count <= free_count_next;
      done       <= done_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    cmd         <= cmd_next;
    val_q       <= val_q_next;
    key_q       <= key_q_next;
    raw_shift   <= raw_shift_next;
    sum         <= sum_next;
    len         <= len_next;
    ended       <= ended_next;
    scan_cnt    <= scan_cnt_next;
    pos         <= pos_next;
    probe_cnt   <= probe_cnt_next;
    status      <= status_next;
    found_value <= found_value_next;
    slot        <= slot_next;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[pos];
  end

endmodule
`default_nettype wire

// ----- dv/lphm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_checker
// watches the request, result and config ports of the hash map, keeps its own
// copy of the table and compares each result with the predicted outcome
// ----------------------------------------------------------------------------
module lphm_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BYTES   = 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  input  wire                                   busy,
  input  wire                                   command,
  input  wire  [lphm_pkg::KEY_W-1:0]            key,
  input  wire  [lphm_pkg::VAL_W-1:0]            value,
  input  wire                                   done,
  input  wire  [1:0]                            status,
  input  wire  [lphm_pkg::VAL_W-1:0]            found_value,
  input  wire  [lphm_pkg::OUT_SLOT_W-1:0]       slot,
  input  wire                                   cfg_write,
  input  wire  [lphm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [lphm_pkg::CFG_W-1:0]            cfg_data,
  output int                                    fail_count,
  output int                                    pending_count
);

  localparam int KEY_W      = lphm_pkg::KEY_W;
  localparam int VAL_W      = lphm_pkg::VAL_W;
  localparam int OUT_SLOT_W = lphm_pkg::OUT_SLOT_W;
  localparam int SIZE_W     = lphm_pkg::SIZE_W;
  localparam int LIMIT_W    = lphm_pkg::LIMIT_W;

  typedef struct packed {
    lphm_pkg::status_t     status;
    logic [VAL_W-1:0]      value;
    logic [OUT_SLOT_W-1:0] slot;
  } outcome_t;

  outcome_t pending_outcomes[$];

  logic             slot_taken [TABLE_DEPTH];
  logic [KEY_W-1:0] slot_keys  [TABLE_DEPTH];
  logic [VAL_W-1:0] slot_vals  [TABLE_DEPTH];
  int               open_slots;
  logic [SIZE_W-1:0]  size_setting;
  logic [LIMIT_W-1:0] keylen_setting;

  function automatic int active_size();
    if (size_setting == 0) return 1;
    if (size_setting > TABLE_DEPTH) return TABLE_DEPTH;
    return size_setting;
  endfunction

  task automatic wipe_table();
    int n;
    for (n = 0; n < TABLE_DEPTH; n++) begin
      slot_taken[n] = 1'b0;
      slot_keys[n]  = '0;
      slot_vals[n]  = '0;
    end
    open_slots = active_size();
  endtask

  task automatic predict_outcome(input logic cmd, input logic [KEY_W-1:0] raw,
                                 input logic [VAL_W-1:0] val, output outcome_t res);
    logic [KEY_W-1:0] nkey;
    logic [7:0]       b;
    int len, sum, pos, lim, sz, n;
    bit stop, hit;
    nkey = '0;
    len  = 0;
    sum  = 0;
    stop = 0;
    hit  = 0;
    sz   = active_size();
    lim  = (keylen_setting > KEY_BYTES) ? KEY_BYTES : keylen_setting;
    // bytes up to the first zero byte make the key
    for (n = 0; n < KEY_BYTES; n++) begin
      if (!stop) begin
        b = raw[8*n +: 8];
        if (b == 8'd0) stop = 1;
        else begin
          nkey[8*n +: 8] = b;
          sum += b;
          len++;
        end
      end
    end
    res.status = lphm_pkg::ST_NOT_FOUND;
    res.value  = '0;
    res.slot   = '0;
    if (cmd == lphm_pkg::CMD_INSERT && open_slots < 1) begin
      res.status = lphm_pkg::ST_FULL;
    end else if (len > lim) begin
      res.status = (cmd == lphm_pkg::CMD_INSERT) ? lphm_pkg::ST_TOO_LONG
                                                 : lphm_pkg::ST_NOT_FOUND;
    end else begin
      pos = sum % sz;
      for (n = 0; n < sz && !hit; n++) begin
        if (!slot_taken[pos] || slot_keys[pos] == nkey) hit = 1;
        else begin
          pos++;
          if (pos >= sz) pos = 0;
        end
      end
      if (cmd == lphm_pkg::CMD_INSERT) begin
        if (hit) begin
          if (!slot_taken[pos]) begin
            slot_taken[pos] = 1'b1;
            slot_keys[pos]  = nkey;
            open_slots--;
          end
          slot_vals[pos] = val;
          res.status = lphm_pkg::ST_OK;
          res.slot   = pos[OUT_SLOT_W-1:0];
        end else begin
          res.status = lphm_pkg::ST_FULL;
        end
      end else if (hit && slot_taken[pos]) begin
        res.status = lphm_pkg::ST_OK;
        res.value  = slot_vals[pos];
        res.slot   = pos[OUT_SLOT_W-1:0];
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t res;
    outcome_t want;
    if (rst) begin
      size_setting   = 7'd64;
      keylen_setting = 4'd8;
      wipe_table();
      pending_outcomes.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == lphm_pkg::REG_TABLE_SIZE) begin
          size_setting = cfg_data[SIZE_W-1:0];
          wipe_table();
        end else if (cfg_index == lphm_pkg::REG_MAX_KEY_LENGTH) begin
          keylen_setting = cfg_data[LIMIT_W-1:0];
        end
      end
      if (start && !busy) begin
        predict_outcome(command, key, value, res);
        pending_outcomes.push_back(res);
      end
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got status %0d value %h slot %0d",
                   $time, status, found_value, slot);
        end else begin
          want = pending_outcomes.pop_front();
          if (status !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, status);
          end
          if (found_value !== want.value) begin
            fail_count++;
            $display("%0t: found_value mismatch, expected %h got %h",
                     $time, want.value, found_value);
          end
          if (slot !== want.slot) begin
            fail_count++;
            $display("%0t: slot mismatch, expected %0d got %0d",
                     $time, want.slot, slot);
          end
        end
      end
    end
    pending_count = pending_outcomes.size();
  end

endmodule

// ----- dv/linear_probe_hash_map_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_tb
// drives insert and find requests and config writes into the hash map; the
// checker beside it predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module linear_probe_hash_map_tb;

  localparam int TABLE_DEPTH  = 64;
  localparam int KEY_BYTES    = 8;
  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_TAIL   = 300;      // last requests go without idling
  localparam int CYCLE_LIMIT  = 1000000;
  // worst single request plus margin
  localparam int DRAIN_CYCLES = KEY_BYTES + 12 + 2 * TABLE_DEPTH + 16;

  localparam int KEY_W      = lphm_pkg::KEY_W;
  localparam int VAL_W      = lphm_pkg::VAL_W;
  localparam int OUT_SLOT_W = lphm_pkg::OUT_SLOT_W;
  localparam int CFG_IDX_W  = lphm_pkg::CFG_IDX_W;
  localparam int CFG_W      = lphm_pkg::CFG_W;
  localparam int LIMIT_W    = lphm_pkg::LIMIT_W;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 command;
  logic [KEY_W-1:0]     key;
  logic [VAL_W-1:0]     value;
  logic                 done;
  logic [1:0]           status;
  logic [VAL_W-1:0]     found_value;
  logic [OUT_SLOT_W-1:0] slot;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending_count;
  int cycles;

  linear_probe_hash_map #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .key        (key),
    .value      (value),
    .done       (done),
    .status     (status),
    .found_value(found_value),
    .slot       (slot),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lphm_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES)
  ) chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .key          (key),
    .value        (value),
    .done         (done),
    .status       (status),
    .found_value  (found_value),
    .slot         (slot),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, a hang or a lost result ends up here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // key of len nonzero bytes, low byte first; junk puts random bytes past
  // the terminating zero byte, which the block must ignore
  function automatic logic [KEY_W-1:0] build_key(input int len, input bit junk);
    logic [KEY_W-1:0] k;
    int i;
    k = '0;
    for (i = 0; i < KEY_BYTES; i++) begin
      if (i < len) k[8*i +: 8] = 8'($urandom_range(1, 255));
      else if (i > len && junk) k[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return k;
  endfunction

  // one request; optional idle burst first, either right after the last
  // accept or once the block has gone idle, so gaps hit both phases
  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v, input bit allow_idle);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      start   = 1'b0;
      // junk on the payload while start is low
      command = 1'($urandom_range(0, 1));
      key     = {$urandom, $urandom};
      value   = $urandom;
      if ($urandom_range(0, 1)) begin
        while (busy) @(negedge clk);
      end
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   = 1'b1;
    command = cmd;
    key     = k;
    value   = v;
    // request goes in at the first edge with busy low
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // config writes only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    logic [CFG_W-1:0] data;
    logic             cmd;
    logic [KEY_W-1:0] pool_key[$];
    int               pool_len[$];
    int sent, phase_items, i, j, n, len, lim, mkl, pool_n;
    bit idle_phase;

    rst       = 1'b1;
    start     = 1'b0;
    command   = 1'b0;
    key       = '0;
    value     = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cycles    = 0;
    sent      = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // ---- directed part, reset config: 64 slots, 8 byte keys ----
    // empty key on an empty table
    send_request(lphm_pkg::CMD_FIND,   64'h0, 32'h0, 0);
    // all ones key, largest byte sum
    send_request(lphm_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 0);
    send_request(lphm_pkg::CMD_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0);
    // update of an existing key
    send_request(lphm_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 0);
    send_request(lphm_pkg::CMD_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    // bytes past the terminator are ignored
    send_request(lphm_pkg::CMD_INSERT, 64'hAB00_0000_0000_0041, 32'h0000_0001, 0);
    send_request(lphm_pkg::CMD_FIND,   64'h0000_0000_0000_0041, 32'h0, 0);
    // empty key stored, then found with junk above its zero byte
    send_request(lphm_pkg::CMD_INSERT, 64'h0, 32'hFFFF_FFFF, 0);
    send_request(lphm_pkg::CMD_FIND,   64'h1234_5600, 32'h0, 0);
    // two keys with the same byte sum, second one probes forward
    send_request(lphm_pkg::CMD_INSERT, 64'h0102, 32'h0000_1111, 0);
    send_request(lphm_pkg::CMD_INSERT, 64'h0201, 32'h0000_2222, 0);
    send_request(lphm_pkg::CMD_FIND,   64'h0201, 32'h0, 0);
    send_request(lphm_pkg::CMD_FIND,   64'h0102, 32'h0, 0);
    // key length zero: only the empty key passes, upper data bits masked
    write_reg(lphm_pkg::REG_MAX_KEY_LENGTH, 7'h70);
    send_request(lphm_pkg::CMD_INSERT, 64'h41, 32'h0000_0005, 0);
    send_request(lphm_pkg::CMD_FIND,   64'h41, 32'h0, 0);
    send_request(lphm_pkg::CMD_INSERT, 64'h0, 32'h0000_0006, 0);
    // length above the key width acts as the full width
    write_reg(lphm_pkg::REG_MAX_KEY_LENGTH, 7'h7F);
    send_request(lphm_pkg::CMD_INSERT, 64'h0807_0605_0403_0201, 32'h0000_0007, 0);
    // size zero acts as one slot: full table, also for a present key
    write_reg(lphm_pkg::REG_TABLE_SIZE, 7'd0);
    send_request(lphm_pkg::CMD_INSERT, 64'h41, 32'h0000_0008, 0);
    send_request(lphm_pkg::CMD_INSERT, 64'h42, 32'h0000_0009, 0);
    send_request(lphm_pkg::CMD_INSERT, 64'h41, 32'h0000_000A, 0);
    send_request(lphm_pkg::CMD_FIND,   64'h41, 32'h0, 0);
    // miss on a full table, probe must stop
    send_request(lphm_pkg::CMD_FIND,   64'h42, 32'h0, 0);
    // size above the depth acts as the depth
    write_reg(lphm_pkg::REG_TABLE_SIZE, 7'd127);
    send_request(lphm_pkg::CMD_INSERT, 64'hFF01, 32'h0000_000B, 0);

    // ---- random phases ----
    while (sent < RANDOM_ITEMS) begin
      // small tables are favored so full and wrap cases come often
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0:       data = 7'd0;
          1:       data = 7'd1;
          2:       data = 7'd2;
          3:       data = CFG_W'($urandom_range(3, 5));
          4:       data = CFG_W'($urandom_range(6, 12));
          5:       data = CFG_W'($urandom_range(13, 31));
          6:       data = 7'd64;
          7:       data = CFG_W'($urandom_range(65, 127));
          default: data = CFG_W'($urandom_range(1, 8));
        endcase
        write_reg(lphm_pkg::REG_TABLE_SIZE, data);
      end
      case ($urandom_range(0, 5))
        0:       mkl = $urandom_range(0, 15);
        1:       mkl = 8;
        default: mkl = $urandom_range(1, 8);
      endcase
      data = CFG_W'($urandom_range(0, 127));
      data[LIMIT_W-1:0] = LIMIT_W'(mkl);
      write_reg(lphm_pkg::REG_MAX_KEY_LENGTH, data);
      lim = (mkl > KEY_BYTES) ? KEY_BYTES : mkl;

      // pool of keys reused within the phase so finds and updates hit
      pool_key.delete();
      pool_len.delete();
      pool_n = $urandom_range(3, 24);
      for (i = 0; i < pool_n; i++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, KEY_BYTES)
                                          : $urandom_range(0, lim);
        pool_key.push_back(build_key(len, 1'($urandom_range(0, 1))));
        pool_len.push_back(len);
      end

      idle_phase  = ($urandom_range(0, 2) != 0);
      phase_items = $urandom_range(30, 110);
      for (i = 0; i < phase_items && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          j   = $urandom_range(0, pool_key.size() - 1);
          k   = pool_key[j];
          len = pool_len[j];
          // same key with fresh junk above the terminator
          if (len < KEY_BYTES - 1 && $urandom_range(0, 3) == 0) begin
            for (n = len + 1; n < KEY_BYTES; n++) k[8*n +: 8] = 8'($urandom_range(0, 255));
          end
        end else begin
          // noise: any length, any junk
          k = build_key($urandom_range(0, KEY_BYTES), 1'($urandom_range(0, 1)));
        end
        case ($urandom_range(0, 9))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          default: v = $urandom;
        endcase
        cmd = $urandom_range(0, 1) ? lphm_pkg::CMD_FIND : lphm_pkg::CMD_INSERT;
        send_request(cmd, k, v, idle_phase && (sent < RANDOM_ITEMS - QUIET_TAIL));
        sent++;
      end
    end

    // ---- drain ----
    @(negedge clk);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
